@@ src/glr_pkg.sv @@
// shared constants and types for the grid line rasterizer
`default_nettype none

package glr_pkg;

   localparam int COORD_W     = 6;
   localparam int ROW_W       = 7;
   localparam int GRID_W      = 7;
   localparam int INDEX_W     = 13;
   localparam int ERR_W       = 15;
   localparam int DCOL_W      = COORD_W;
   localparam int DROW_W      = COORD_W + 1;
   localparam int QUEUE_DEPTH = 2;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_FIELD_W = COORD_W + ROW_W + INDEX_W;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   localparam logic [GRID_W-1:0] GRID_SIDE_RESET = GRID_W'(10);

   // one line as it travels from the front end to the walker
   typedef struct packed {
      logic [COORD_W-1:0]        start_x;
      logic [COORD_W-1:0]        start_y;
      logic [COORD_W-1:0]        stop_x;
      logic [DCOL_W-1:0]         delta_col;
      logic signed [DROW_W-1:0]  delta_row;
   } line_type;

endpackage

`default_nettype wire

@@ src/glr_queue.sv @@
// short line queue between the front end and the walker
`default_nettype none

module glr_queue
   import glr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire line_type in_line,
   output logic          out_valid,
   input  wire logic     out_ready,
   output line_type      out_line
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   line_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_line  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_line;
      end
   end

endmodule

`default_nettype wire

@@ src/glr_front.sv @@
// front end: takes line words, drops backward lines, queues the rest
`default_nettype none

module glr_front
   import glr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       line_valid,
   input  wire logic                  line_ready,
   output line_type                   line_out
);

   logic [COORD_W-1:0] start_x, start_y, end_x, end_y;
   logic               backward;
   logic               q_in_ready;
   line_type           line_in;

   assign start_x = req_tdata[COORD_W-1:0];
   assign start_y = req_tdata[2*COORD_W-1:COORD_W];
   assign end_x   = req_tdata[3*COORD_W-1:2*COORD_W];
   assign end_y   = req_tdata[4*COORD_W-1:3*COORD_W];

   assign backward = (end_x < start_x);

   always_comb begin
      line_in.start_x   = start_x;
      line_in.start_y   = start_y;
      line_in.stop_x    = end_x;
      line_in.delta_col = end_x - start_x;
      line_in.delta_row = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
   end

   // backward lines are taken and dropped, they produce no points
   assign req_tready = q_in_ready;

   glr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && !backward),
      .in_ready  (q_in_ready),
      .in_line   (line_in),
      .out_valid (line_valid),
      .out_ready (line_ready),
      .out_line  (line_out)
   );

endmodule

`default_nettype wire

@@ src/glr_back.sv @@
// walker: steps one column per cycle unless stalled and registers each point for output
`default_nettype none

module glr_back
   import glr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [GRID_W-1:0] grid_side,
   input  wire logic              line_valid,
   output logic                   line_ready,
   input  wire line_type          line_in,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [COORD_W-1:0]     point_x,
   output logic [ROW_W-1:0]       point_y,
   output logic [INDEX_W-1:0]     vertex_index,
   output logic                   off_grid,
   output logic                   last_point
);

   logic                     busy_ff, busy_in;
   logic [COORD_W-1:0]       cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]         cur_row_ff, cur_row_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [COORD_W-1:0]       stop_col_ff, stop_col_in;
   logic [DCOL_W-1:0]        dcol_ff, dcol_in;
   logic signed [DROW_W-1:0] drow_ff, drow_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]       rsp_x_ff;
   logic [ROW_W-1:0]         rsp_y_ff;
   logic [INDEX_W-1:0]       rsp_idx_ff;
   logic                     rsp_off_ff;
   logic                     rsp_last_ff;

   logic                     load, emit, at_last, row_step;
   logic signed [ERR_W-1:0]  err_sum, twice_drow, twice_dcol, dcol_ext;
   logic [INDEX_W-1:0]       idx;
   logic                     off;

   assign line_ready = !busy_ff;
   assign load       = line_valid && !busy_ff;
   assign emit       = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign at_last    = (cur_col_ff == stop_col_ff);

   assign twice_drow = {{(ERR_W-DROW_W-1){drow_ff[DROW_W-1]}}, drow_ff, 1'b0};
   assign twice_dcol = {{(ERR_W-DCOL_W-1){1'b0}}, dcol_ff, 1'b0};
   assign dcol_ext   = {{(ERR_W-DCOL_W){1'b0}}, dcol_ff};
   assign err_sum    = err_ff + twice_drow;
   assign row_step   = (err_sum >= dcol_ext);

   assign idx = INDEX_W'(cur_col_ff) * INDEX_W'(grid_side) + INDEX_W'(cur_row_ff);
   assign off = ({1'b0, cur_col_ff} >= grid_side) || (cur_row_ff >= grid_side);

   always_comb begin
      busy_in     = busy_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      err_in      = err_ff;
      stop_col_in = stop_col_ff;
      dcol_in     = dcol_ff;
      drow_in     = drow_ff;
      if (load) begin
         busy_in     = 1'b1;
         cur_col_in  = line_in.start_x;
         cur_row_in  = {1'b0, line_in.start_y};
         err_in      = '0;
         stop_col_in = line_in.stop_x;
         dcol_in     = line_in.delta_col;
         drow_in     = line_in.delta_row;
      end else if (emit) begin
         err_in     = row_step ? err_sum - twice_dcol : err_sum;
         cur_row_in = row_step ? cur_row_ff + ROW_W'(1) : cur_row_ff;
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            cur_col_in = cur_col_ff + COORD_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         err_ff       <= '0;
         stop_col_ff  <= '0;
         dcol_ff      <= '0;
         drow_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         err_ff       <= err_in;
         stop_col_ff  <= stop_col_in;
         dcol_ff      <= dcol_in;
         drow_ff      <= drow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x_ff    <= cur_col_ff;
         rsp_y_ff    <= cur_row_ff;
         rsp_idx_ff  <= idx;
         rsp_off_ff  <= off;
         rsp_last_ff <= at_last;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign point_x      = rsp_x_ff;
   assign point_y      = rsp_y_ff;
   assign vertex_index = rsp_idx_ff;
   assign off_grid     = rsp_off_ff;
   assign last_point   = rsp_last_ff;

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      emit && at_last |=> !busy_ff)
      else $error("walker still busy after the last point");

   a_load_starts_walk: assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff && !line_ready)
      else $error("line taken but walker not busy");

   a_emit_fills_output: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && (rsp_x_ff == $past(cur_col_ff)))
      else $error("emitted point not in output register");

   a_column_advances: assert property (@(posedge clock) disable iff (reset)
      emit && !at_last |=> cur_col_ff == $past(cur_col_ff) + COORD_W'(1))
      else $error("column did not advance by one");

   a_stall_holds_walk: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !emit |=> $stable(cur_col_ff) && $stable(err_ff))
      else $error("walker moved while output stalled");

endmodule

`default_nettype wire

@@ src/grid_line_rasterizer.sv @@
// grid line rasterizer: walks a first-octant line one column per cycle unless rsp_ stalls
//
// A line word on req_ carries start and end grid coordinates. The front end
// drops lines whose end column lies left of the start column and queues the
// rest (two lines deep). The walker emits one point word per column on rsp_,
// from start column to end column, with rsp_tlast on the final point.
// Each point carries its column, row, row plus column times grid_side, and
// in rsp_tuser a flag set when column or row is not below grid_side.
// The first point of a line passes through the queue, the walker's registers and
// the output register before rsp_tvalid rises. The walker loads a line from the
// queue, emits its points and takes no new line until it has emitted the last one.
// A stalled rsp_ holds the output register and freezes the walker; req_ keeps
// taking line words until the queue is full.
// Users write grid_side through csr_ only while the block is idle; the block does not
// enforce it. Reset sets it to 10 and empties the queue, walker and output register.
`default_nettype none

module grid_line_rasterizer
   import glr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [GRID_W-1:0]     csr_wr_data,   // grid_side
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,     // start_x, start_y, end_x, end_y
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,     // point_x, point_y, vertex_index, pad
   output logic                       rsp_tuser,     // off_grid
   output logic                       rsp_tlast
);

   logic [GRID_W-1:0]  grid_side_ff, grid_side_in;
   logic               line_valid, line_ready;
   line_type           line;
   logic [COORD_W-1:0] point_x;
   logic [ROW_W-1:0]   point_y;
   logic [INDEX_W-1:0] vertex_index;

   assign grid_side_in = csr_wr_en ? csr_wr_data : grid_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= GRID_SIDE_RESET;
      end else begin
         grid_side_ff <= grid_side_in;
      end
   end

   glr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .line_valid (line_valid),
      .line_ready (line_ready),
      .line_out   (line)
   );

   glr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .grid_side    (grid_side_ff),
      .line_valid   (line_valid),
      .line_ready   (line_ready),
      .line_in      (line),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .point_x      (point_x),
      .point_y      (point_y),
      .vertex_index (vertex_index),
      .off_grid     (rsp_tuser),
      .last_point   (rsp_tlast)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, vertex_index, point_y, point_x};

endmodule

`default_nettype wire

@@ tb/tb_grid_line_rasterizer.sv @@
// self-checking testbench for the grid line rasterizer: random and directed lines
`default_nettype none

module tb_grid_line_rasterizer;
   import glr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 80;
   localparam int WATCHDOG_LIMIT = 4000;

   // one line word, start_x in the lowest bits
   typedef struct packed {
      logic [COORD_W-1:0] end_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] start_x;
   } line_word_type;

   typedef struct packed {
      logic               last;
      logic               off;
      logic [INDEX_W-1:0] vindex;
      logic [ROW_W-1:0]   y;
      logic [COORD_W-1:0] x;
   } point_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [GRID_W-1:0]     csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   line_word_type     pending_lines[$];
   point_type         expected_points[$];
   logic [GRID_W-1:0] grid_side_now = GRID_SIDE_RESET;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                hold_req_seq = 0;
   int                hold_seen = 0;
   int                hold_left = 0;
   int                idle_cycles = 0;
   int                fail_count = 0;
   bit                line_taken = 1'b0;

   grid_line_rasterizer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // walk one line the way the block should, queueing every point it emits
   task automatic trace_line(input line_word_type ln);
      int                 dcol;
      int                 drow;
      int                 err;
      int                 gs;
      logic [COORD_W-1:0] col;
      logic [ROW_W-1:0]   row;
      point_type          p;
      bit                 done;
      if (ln.end_x < ln.start_x) return;
      dcol = int'(ln.end_x) - int'(ln.start_x);
      drow = int'(ln.end_y) - int'(ln.start_y);
      gs   = int'(grid_side_now);
      err  = 0;
      col  = ln.start_x;
      row  = ROW_W'(ln.start_y);
      done = 1'b0;
      while (!done) begin
         p.x      = col;
         p.y      = row;
         p.vindex = INDEX_W'(int'(row) + int'(col) * gs);
         p.off    = (int'(col) >= gs) || (int'(row) >= gs);
         p.last   = (col == ln.end_x);
         expected_points.insert(expected_points.size(), p);
         err += 2 * drow;
         // steep lines still climb at most one row per column
         if (err >= dcol) begin
            row = row + 1'b1;
            err -= 2 * dcol;
         end
         if (p.last) done = 1'b1;
         else col = col + 1'b1;
      end
   endtask

   function automatic void compare_field(string name, logic [INDEX_W-1:0] want,
                                         logic [INDEX_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // line word driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || line_taken)) begin
         if (pending_lines.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata  <= pending_lines.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // point word receiver, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_seen != hold_req_seq) begin
         hold_seen = hold_req_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      point_type got;
      point_type want;
      bit        point_taken;
      line_taken  = !reset && req_tvalid && req_tready;
      point_taken = !reset && rsp_tvalid && rsp_tready;
      if (line_taken) trace_line(line_word_type'(req_tdata));
      if (point_taken) begin
         got.x      = rsp_tdata[COORD_W-1:0];
         got.y      = rsp_tdata[COORD_W +: ROW_W];
         got.vindex = rsp_tdata[COORD_W+ROW_W +: INDEX_W];
         got.off    = rsp_tuser;
         got.last   = rsp_tlast;
         if (expected_points.size() == 0) begin
            $display("%0t ns: unexpected point, expected none, actual x=%0d y=%0d",
                     $time, got.x, got.y);
            fail_count++;
         end else begin
            want = expected_points.pop_front();
            compare_field("point_x", INDEX_W'(want.x), INDEX_W'(got.x));
            compare_field("point_y", INDEX_W'(want.y), INDEX_W'(got.y));
            compare_field("vertex_index", want.vindex, got.vindex);
            compare_field("off_grid", INDEX_W'(want.off), INDEX_W'(got.off));
            compare_field("last_point", INDEX_W'(want.last), INDEX_W'(got.last));
         end
      end
      if (reset || line_taken || point_taken || csr_wr_en) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, idle_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic add_line(input int sx, input int sy, input int ex, input int ey);
      line_word_type ln;
      ln.start_x = COORD_W'(sx);
      ln.start_y = COORD_W'(sy);
      ln.end_x   = COORD_W'(ex);
      ln.end_y   = COORD_W'(ey);
      pending_lines.insert(pending_lines.size(), ln);
   endtask

   // mostly forward lines of short span, some nearly full-width, vertical and backward ones
   task automatic add_random_lines(input int count);
      int kind;
      int sx;
      int ex;
      int forward;
      forward = 0;
      while (forward < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 12) begin
            ex = $urandom_range(0, 62);
            sx = $urandom_range(ex + 1, 63);
         end else if (kind < 22) begin
            sx = $urandom_range(0, 63);
            ex = sx;
         end else if (kind < 40) begin
            sx = $urandom_range(0, 7);
            ex = $urandom_range(56, 63);
         end else begin
            sx = $urandom_range(0, 63);
            ex = $urandom_range(sx, (sx + 15 > 63) ? 63 : sx + 15);
         end
         if (ex >= sx) forward++;
         add_line(sx, $urandom_range(0, 63), ex, $urandom_range(0, 63));
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_lines.size() > 0 || req_tvalid || expected_points.size() > 0);
      // backward lines leave nothing to wait for, so give the walker time to finish
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_grid_side(input int value);
      @(negedge clock);
      csr_wr_en     = 1'b1;
      csr_wr_data   = GRID_W'(value);
      grid_side_now = GRID_W'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic run_phase(input int grid, input int send_pct, input int recv_pct,
                            input int count, input bit hold);
      write_grid_side(grid);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (hold) hold_req_seq++;
      add_line(0, 0, 63, 63);
      add_line(63, 63, 63, 63);
      add_random_lines(count);
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed lines under the reset grid side
      add_line(0, 0, 63, 63);
      add_line(0, 0, 63, 0);
      add_line(0, 63, 63, 63);
      add_line(63, 63, 63, 63);
      add_line(0, 0, 0, 0);
      add_line(9, 9, 9, 9);
      add_line(10, 0, 10, 63);
      add_line(5, 3, 2, 7);
      add_line(63, 0, 0, 63);
      add_line(0, 63, 63, 0);
      add_line(20, 40, 30, 5);
      add_line(10, 20, 15, 60);
      add_line(0, 0, 3, 63);
      add_line(0, 0, 63, 31);
      add_line(0, 0, 63, 32);
      add_line(3, 4, 9, 8);
      add_line(20, 5, 40, 15);
      add_line(1, 1, 2, 2);
      add_line(62, 62, 63, 63);
      add_line(42, 21, 50, 42);
      add_line(21, 42, 42, 21);
      add_line(8, 8, 12, 10);
      wait_drained();

      run_phase(10, 0, 0, 45, 1'b0);
      run_phase(1, 70, 0, 45, 1'b0);
      run_phase(64, 0, 70, 45, 1'b0);
      // zero grid side: every point is off the grid and the index is the row
      run_phase(0, 38, 38, 45, 1'b0);
      run_phase(127, 0, 0, 35, 1'b1);
      run_phase(37, 38, 38, 45, 1'b0);
      run_phase(63, 70, 70, 45, 1'b0);
      run_phase(10, 0, 38, 45, 1'b0);

      if (expected_points.size() != 0) begin
         $display("%0t ns: %0d points expected but never seen", $time, expected_points.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
src/glr_pkg.sv
src/glr_queue.sv
src/glr_front.sv
src/glr_back.sv
src/grid_line_rasterizer.sv
tb/tb_grid_line_rasterizer.sv
